FILE: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int CFG_IDX_W = 2;
  localparam int ERR_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO_EXP = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO_MOD = 2'd2;

  typedef logic [1:0] op_t;

  // Which modular product the shared multiplier forms.
  localparam op_t OP_RED = 2'd0;  // base mod m, as (1 mod m) * base
  localparam op_t OP_SQR = 2'd1;  // r * r
  localparam op_t OP_MUL = 2'd2;  // r * base

  typedef struct packed {
    logic             load;
    logic             start;
    logic             step;
    logic             commit;
    logic             out_load;
    op_t              op;
    logic [CNT_W-1:0] ebit_idx;
    logic [ERR_W-1:0] err;
  } mexp_cmd_t;

  typedef struct packed {
    logic e_zero;
    logic m_zero;
    logic e_bit;
  } mexp_sts_t;

endpackage

FILE: hw/rtl/mexp_dp.sv
`timescale 1ns / 1ps

module mexp_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mexp_pkg::WIDTH-1:0]      cfg_data,
  input  logic [mexp_pkg::WIDTH-1:0]      in_base_value,
  input  mexp_pkg::mexp_cmd_t             cmd,
  output mexp_pkg::mexp_sts_t             sts,
  output logic [mexp_pkg::WIDTH-1:0]      out_power_result,
  output logic [mexp_pkg::ERR_W-1:0]      out_error_code
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] mod_r;
  logic [WIDTH-1:0] exp_r;
  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] pow_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] mcand_r;
  logic [WIDTH-1:0] mplier_r;
  logic [WIDTH-1:0] res_r;
  logic [ERR_W-1:0] err_r;

  logic [WIDTH-1:0] one_mod;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] dbl_add;
  logic [WIDTH-1:0] acc_nxt;

  // (x + y) mod m for x, y < m; the sum carries one extra bit.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    if (s >= {1'b0, m}) begin
      add_mod = d[WIDTH-1:0];
    end else begin
      add_mod = s[WIDTH-1:0];
    end
  endfunction

  assign one_mod = (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  // One multiplier bit per cycle, most significant first.
  assign dbl     = add_mod(acc_r, acc_r, mod_r);
  assign dbl_add = add_mod(dbl, mcand_r, mod_r);
  assign acc_nxt = mplier_r[WIDTH-1] ? dbl_add : dbl;

  assign sts.e_zero = (exp_r == '0);
  assign sts.m_zero = (mod_r == '0);
  assign sts.e_bit  = exp_r[cmd.ebit_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
      exp_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODULUS:  mod_r <= cfg_data;
        REG_EXPONENT: exp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_base_value;
      pow_r  <= one_mod;
    end
    if (cmd.start) begin
      acc_r <= '0;
      case (cmd.op)
        OP_RED: begin
          mcand_r  <= one_mod;
          mplier_r <= base_r;
        end
        OP_SQR: begin
          mcand_r  <= pow_r;
          mplier_r <= pow_r;
        end
        default: begin
          mcand_r  <= pow_r;
          mplier_r <= base_r;
        end
      endcase
    end else if (cmd.step) begin
      acc_r    <= acc_nxt;
      mplier_r <= {mplier_r[WIDTH-2:0], 1'b0};
    end
    if (cmd.commit) begin
      if (cmd.op == OP_RED) begin
        base_r <= acc_r;
      end else begin
        pow_r <= acc_r;
      end
    end
    if (cmd.out_load) begin
      res_r <= (cmd.err == ERR_OK) ? pow_r : '0;
      err_r <= cmd.err;
    end
  end

  assign out_power_result = res_r;
  assign out_error_code   = err_r;

endmodule

FILE: hw/rtl/mexp_ctrl.sv
`timescale 1ns / 1ps

module mexp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mexp_pkg::mexp_sts_t  sts,
  output mexp_pkg::mexp_cmd_t  cmd
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_NEXT   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ebit_r, ebit_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cnt_nxt      = cnt_r;
    ebit_nxt     = ebit_r;
    err_nxt      = err_r;
    cmd          = '0;
    cmd.op       = op_r;
    cmd.ebit_idx = ebit_r;
    cmd.err      = err_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.e_zero) begin
          err_nxt   = ERR_ZERO_EXP;
          state_nxt = S_FIN;
        end else if (sts.m_zero) begin
          err_nxt   = ERR_ZERO_MOD;
          state_nxt = S_FIN;
        end else begin
          err_nxt   = ERR_OK;
          cmd.start = 1'b1;
          cmd.op    = OP_RED;
          op_nxt    = OP_RED;
          cnt_nxt   = '0;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        // Scan the exponent from its top bit: square, then multiply on a one.
        cnt_nxt = '0;
        if (op_r == OP_RED) begin
          ebit_nxt  = CNT_W'(WIDTH - 1);
          cmd.start = 1'b1;
          cmd.op    = OP_SQR;
          op_nxt    = OP_SQR;
          state_nxt = S_STEP;
        end else if (op_r == OP_SQR && sts.e_bit) begin
          cmd.start = 1'b1;
          cmd.op    = OP_MUL;
          op_nxt    = OP_MUL;
          state_nxt = S_STEP;
        end else if (ebit_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          ebit_nxt  = ebit_r - CNT_W'(1);
          cmd.start = 1'b1;
          cmd.op    = OP_SQR;
          op_nxt    = OP_SQR;
          state_nxt = S_STEP;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_RED;
      cnt_r       <= '0;
      ebit_r      <= '0;
      err_r       <= ERR_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      ebit_r      <= ebit_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/modular_exponentiation_unit.sv
// Each modular product is a start, 32 shift-add steps and a commit. One product reduces the
// base, then the exponent takes 32 squarings plus one multiply per one bit of the exponent;
// error cases (zero exponent or modulus) skip the products and go straight to the result.
// One request at a time, set by the single shift-add modular multiplier; the next request
// is accepted the cycle after the result is loaded.
// Reset (rst_n, synchronous, active low) clears the modulus and exponent to zero and idles.
`timescale 1ns / 1ps

module modular_exponentiation_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mexp_pkg::WIDTH-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mexp_pkg::WIDTH-1:0]      in_base_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mexp_pkg::WIDTH-1:0]      out_power_result,
  output logic [mexp_pkg::ERR_W-1:0]      out_error_code
);
  import mexp_pkg::*;

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mexp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_base_value    (in_base_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_power_result (out_power_result),
    .out_error_code   (out_error_code)
  );

endmodule
